FILE: rtl/core/wft_pkg.sv
package wft_pkg;

   localparam int unsigned CARD_W     = 32;
   localparam int unsigned FRAME_W    = 34;
   localparam int unsigned POS_W      = 6;
   localparam int unsigned TICK_REG_W = 20;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [POS_W-1:0] LEN_26 = POS_W'(26);
   localparam logic [POS_W-1:0] LEN_34 = POS_W'(34);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SEND = 1'b1;

   localparam logic FMT_26 = 1'b0;
   localparam logic FMT_34 = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_GAP    = 2'd2;

   localparam logic [TICK_REG_W-1:0] PULSE_WIDTH_RST = TICK_REG_W'(100);
   localparam logic [TICK_REG_W-1:0] PULSE_GAP_RST   = TICK_REG_W'(1000);

   typedef logic [FRAME_W-1:0] frame_type;
   typedef logic [CARD_W-1:0]  card_type;

endpackage

FILE: rtl/core/wft_req_if.sv
interface wft_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   wft_pkg::card_type  card_number;

   modport source (output valid, output command, output card_number, input ready);
   modport sink (input valid, input command, input card_number, output ready);
endinterface

FILE: rtl/core/wft_rsp_if.sv
interface wft_rsp_if;
   logic valid;
   logic ready;
   logic data0_line;
   logic data1_line;
   logic busy_res;
   logic frame_done;

   modport source (output valid, output data0_line, output data1_line, output busy_res,
                   output frame_done, input ready);
   modport sink (input valid, input data0_line, input data1_line, input busy_res,
                 input frame_done, output ready);
endinterface

FILE: rtl/core/wft_csr_if.sv
interface wft_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [wft_pkg::CSR_IDX_W-1:0]        index;
   logic [wft_pkg::TICK_REG_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/wft_frame_build.sv
module wft_frame_build (
   input  logic                frame_format,
   input  wft_pkg::card_type   card_number,
   output wft_pkg::frame_type  frame_bits
);
   import wft_pkg::*;

   logic [23:0] short_data;
   logic        short_even;
   logic        short_odd;
   logic        long_even;
   logic        long_odd;

   assign short_data = card_number[23:0];
   assign short_even = ^short_data[23:12];
   assign short_odd  = ~^short_data[11:0];
   assign long_even  = ^card_number[31:16];
   assign long_odd   = ~^card_number[15:0];

   always_comb begin
      case (frame_format)
         FMT_34:  frame_bits = {long_even, card_number, long_odd};
         default: frame_bits = {short_even, short_data, short_odd, 8'b0};
      endcase
   end

endmodule

FILE: rtl/core/wiegand_frame_transmitter.sv
// Each accepted item's result is registered in the output register.
// Throughput: one item per clock while results are drained; each item is one timing tick or a send command.
// The input is taken whenever the output register is empty or being drained.
// Reset: synchronous, active high; clears the frame sequencer and output valid and
// restores frame_format 0, pulse width 100 and pulse gap 1000 ticks.
module wiegand_frame_transmitter #(
   parameter int unsigned TIMER_BITS = 20
) (
   input  logic       clock,
   input  logic       reset,
   wft_req_if.sink    req_ch,
   wft_rsp_if.source  rsp_ch,
   wft_csr_if.sink    csr_ch
);
   import wft_pkg::*;

   logic                  frame_format_ff;
   logic [TICK_REG_W-1:0] pulse_width_ff;
   logic [TICK_REG_W-1:0] pulse_gap_ff;

   frame_type             frame_bits_ff,      frame_bits_in;
   logic [POS_W-1:0]      bit_position_ff,    bit_position_in;
   logic                  pulse_ff,           pulse_in;
   logic [TIMER_BITS-1:0] countdown_ff,       countdown_in;
   logic                  sending_ff,         sending_in;
   logic                  done_in;

   logic                  rsp_valid_ff;
   logic                  data0_ff,  data0_in;
   logic                  data1_ff,  data1_in;
   logic                  busy_ff;
   logic                  done_ff;

   frame_type             new_frame;
   logic [POS_W-1:0]      frame_len;
   logic [POS_W-1:0]      cur_pos;
   logic [63:0]           msb_first;
   logic                  cur_bit;
   logic                  accept;

   function automatic logic [TIMER_BITS-1:0] phase_load(input logic [TICK_REG_W-1:0] r);
      logic [TIMER_BITS-1:0] v;
      v = TIMER_BITS'(r);
      return (v == '0) ? '0 : v - TIMER_BITS'(1);
   endfunction

   wft_frame_build u_frame_build (
      .frame_format (frame_format_ff),
      .card_number  (req_ch.card_number),
      .frame_bits   (new_frame)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_format_ff <= FMT_26;
         pulse_width_ff  <= PULSE_WIDTH_RST;
         pulse_gap_ff    <= PULSE_GAP_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FRAME_FORMAT: frame_format_ff <= csr_ch.data[0];
            CSR_PULSE_WIDTH:  pulse_width_ff  <= csr_ch.data;
            CSR_PULSE_GAP:    pulse_gap_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign frame_len    = (frame_format_ff == FMT_34) ? LEN_34 : LEN_26;

   // advance the frame sequencer by one item
   always_comb begin
      frame_bits_in   = frame_bits_ff;
      bit_position_in = bit_position_ff;
      pulse_in        = pulse_ff;
      countdown_in    = countdown_ff;
      sending_in      = sending_ff;
      done_in         = 1'b0;
      if (req_ch.command == CMD_SEND) begin
         frame_bits_in   = new_frame;
         bit_position_in = POS_W'(1);
         pulse_in        = 1'b1;
         countdown_in    = phase_load(pulse_width_ff);
         sending_in      = 1'b1;
      end else if (sending_ff) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - TIMER_BITS'(1);
         end else if (pulse_ff) begin
            pulse_in     = 1'b0;
            countdown_in = phase_load(pulse_gap_ff);
         end else if (bit_position_ff >= frame_len) begin
            sending_in = 1'b0;
            done_in    = 1'b1;
         end else begin
            bit_position_in = bit_position_ff + POS_W'(1);
            pulse_in        = 1'b1;
            countdown_in    = phase_load(pulse_width_ff);
         end
      end
   end

   always_comb begin
      msb_first = '0;
      for (int i = 0; i < FRAME_W; i++) begin
         msb_first[i] = frame_bits_in[FRAME_W-1-i];
      end
   end

   assign cur_pos = bit_position_in - POS_W'(1);
   assign cur_bit = msb_first[cur_pos];

   always_comb begin
      data0_in = 1'b1;
      data1_in = 1'b1;
      if (sending_in && pulse_in) begin
         if (cur_bit) begin
            data1_in = 1'b0;
         end else begin
            data0_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_bits_ff   <= '0;
         bit_position_ff <= '0;
         pulse_ff        <= 1'b0;
         countdown_ff    <= '0;
         sending_ff      <= 1'b0;
      end else if (accept) begin
         frame_bits_ff   <= frame_bits_in;
         bit_position_ff <= bit_position_in;
         pulse_ff        <= pulse_in;
         countdown_ff    <= countdown_in;
         sending_ff      <= sending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data0_ff <= data0_in;
         data1_ff <= data1_in;
         busy_ff  <= sending_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.data0_line = data0_ff;
   assign rsp_ch.data1_line = data1_ff;
   assign rsp_ch.busy_res   = busy_ff;
   assign rsp_ch.frame_done = done_ff;

   a_lines_not_both_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (data0_ff || data1_ff))
      else $error("both data lines low");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff)
      else $error("frame done while still busy");

   a_sending_has_bit: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> (bit_position_ff != '0))
      else $error("sending with no bit started");

   a_send_starts_pulse: assert property (@(posedge clock) disable iff (reset)
      accept && (req_ch.command == CMD_SEND) |=> sending_ff && pulse_ff && busy_ff)
      else $error("send did not start a pulse");

   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule

FILE: sim/tb_wiegand_frame_transmitter.sv
module tb_wiegand_frame_transmitter;
   timeunit 1ns;
   timeprecision 1ps;

   import wft_pkg::*;

   localparam int unsigned TIMER_BITS = 20;
   localparam int QUIET_LIMIT = 2000;

   typedef struct packed {
      logic     command;
      card_type card;
   } tx_request_type;

   typedef struct packed {
      logic data0;
      logic data1;
      logic busy;
      logic done;
   } line_state_type;

   logic clock;
   logic reset;

   wft_req_if req_bus ();
   wft_rsp_if rsp_bus ();
   wft_csr_if csr_bus ();

   wiegand_frame_transmitter #(
      .TIMER_BITS(TIMER_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   tx_request_type pending_requests[$];
   line_state_type expected_lines[$];
   int             mismatch_count = 0;
   int             quiet_cycles = 0;
   int             cycle_count = 0;
   logic           req_fire = 1'b0;
   logic           calm;

   // predicted transmitter state and registers
   logic                  cfg_format;
   logic [TICK_REG_W-1:0] cfg_width;
   logic [TICK_REG_W-1:0] cfg_gap;
   frame_type             tx_frame;
   logic [POS_W-1:0]      tx_pos;
   logic                  tx_pulse;
   logic [TIMER_BITS-1:0] tx_count;
   logic                  tx_active;

   assign calm = (cycle_count >= 3000) && (cycle_count < 3600);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [TIMER_BITS-1:0] phase_start(logic [TICK_REG_W-1:0] ticks);
      return (ticks == '0) ? '0 : TIMER_BITS'(ticks - 1'b1);
   endfunction

   function automatic void open_pulse();
      tx_pos = tx_pos + 1'b1;
      tx_pulse = 1'b1;
      tx_count = phase_start(cfg_width);
   endfunction

   function automatic line_state_type advance_frame(tx_request_type rq);
      line_state_type   ls;
      logic [23:0]      short_card;
      logic [POS_W-1:0] last_pos;
      ls.data0 = 1'b1;
      ls.data1 = 1'b1;
      ls.done = 1'b0;
      if (rq.command == CMD_SEND) begin
         if (cfg_format == FMT_34) begin
            tx_frame = {^rq.card[31:16], rq.card, ~^rq.card[15:0]};
         end else begin
            short_card = rq.card[23:0];
            tx_frame = {^short_card[23:12], short_card, ~^short_card[11:0], 8'h00};
         end
         tx_pos = '0;
         tx_active = 1'b1;
         open_pulse();
      end else if (tx_active) begin
         if (tx_count != '0) begin
            tx_count = tx_count - 1'b1;
         end else if (tx_pulse) begin
            tx_pulse = 1'b0;
            tx_count = phase_start(cfg_gap);
         end else if (tx_pos >= ((cfg_format == FMT_34) ? LEN_34 : LEN_26)) begin
            tx_active = 1'b0;
            ls.done = 1'b1;
         end else begin
            open_pulse();
         end
      end
      if (tx_active && tx_pulse) begin
         last_pos = tx_pos - 1'b1;
         if (last_pos <= POS_W'(FRAME_W - 1) && tx_frame[FRAME_W - 1 - last_pos])
            ls.data1 = 1'b0;
         else
            ls.data0 = 1'b0;
      end
      ls.busy = tx_active;
      return ls;
   endfunction

   task automatic check_field(string name, logic want, logic got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      line_state_type seen;
      line_state_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         cfg_format = FMT_26;
         cfg_width = PULSE_WIDTH_RST;
         cfg_gap = PULSE_GAP_RST;
         tx_frame = '0;
         tx_pos = '0;
         tx_pulse = 1'b0;
         tx_count = '0;
         tx_active = 1'b0;
         expected_lines.delete();
         req_fire <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.data0 = rsp_bus.data0_line;
            seen.data1 = rsp_bus.data1_line;
            seen.busy = rsp_bus.busy_res;
            seen.done = rsp_bus.frame_done;
            if (expected_lines.size() == 0) begin
               $display("%0t: unexpected item: expected none, actual %p", $time, seen);
               mismatch_count++;
            end else begin
               want = expected_lines.pop_front();
               check_field("data0_line", want.data0, seen.data0);
               check_field("data1_line", want.data1, seen.data1);
               check_field("busy_res", want.busy, seen.busy);
               check_field("frame_done", want.done, seen.done);
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_FRAME_FORMAT: cfg_format = csr_bus.data[0];
               CSR_PULSE_WIDTH: cfg_width = csr_bus.data;
               CSR_PULSE_GAP: cfg_gap = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            expected_lines.push_back(advance_frame({req_bus.command, req_bus.card_number}));
         req_fire <= req_bus.valid && req_bus.ready;
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      tx_request_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
            nxt = pending_requests.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.command <= nxt.command;
            req_bus.card_number <= nxt.card;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(99) >= 15);
   end

   task automatic queue_send(card_type card);
      pending_requests.push_back({CMD_SEND, card});
   endtask

   task automatic queue_ticks(int count);
      repeat (count) pending_requests.push_back({CMD_TICK, card_type'($urandom)});
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_bus.valid || expected_lines.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [TICK_REG_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_timing(logic fmt, logic [TICK_REG_W-1:0] width,
                             logic [TICK_REG_W-1:0] gap);
      write_reg(CSR_FRAME_FORMAT, TICK_REG_W'(fmt));
      write_reg(CSR_PULSE_WIDTH, width);
      write_reg(CSR_PULSE_GAP, gap);
   endtask

   function automatic int frame_ticks(logic fmt, logic [TICK_REG_W-1:0] width,
                                      logic [TICK_REG_W-1:0] gap);
      int len;
      len = (fmt == FMT_34) ? int'(LEN_34) : int'(LEN_26);
      return len * ((width == '0 ? 1 : int'(width)) + (gap == '0 ? 1 : int'(gap)));
   endfunction

   function automatic logic [TICK_REG_W-1:0] pick_ticks();
      int r;
      r = $urandom_range(9);
      if (r == 0)
         return '0;
      else if (r <= 7)
         return TICK_REG_W'($urandom_range(1, 3));
      else if (r == 8)
         return TICK_REG_W'($urandom_range(4, 6));
      return TICK_REG_W'(1);
   endfunction

   initial begin
      card_type              cards[$];
      logic                  fmt;
      logic [TICK_REG_W-1:0] width;
      logic [TICK_REG_W-1:0] gap;
      int                    full;
      int                    count;
      int                    kind;
      int                    random_items;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_TICK;
      req_bus.card_number = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FRAME_FORMAT;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset timing: idle, first pulse and gap, then a restart
      queue_ticks(3);
      queue_send(32'h00a5_5a5a);
      queue_ticks(1110);
      queue_send(32'h0012_3456);
      queue_ticks(20);
      drain();

      // 26-bit frames with single-tick timing
      set_timing(FMT_26, 1, 1);
      cards = '{32'h0000_0000, 32'hffff_ffff, 32'h00ff_ffff, 32'hff00_0000,
                32'h0080_0001, 32'h0000_0fff};
      foreach (cards[i]) begin
         queue_send(cards[i]);
         queue_ticks(frame_ticks(FMT_26, 1, 1) + 2);
      end
      // restart while busy
      queue_send(32'h0055_aa55);
      queue_ticks(10);
      queue_send(32'h00aa_55aa);
      queue_ticks(frame_ticks(FMT_26, 1, 1) + 2);
      drain();

      // 34-bit frames
      write_reg(CSR_FRAME_FORMAT, TICK_REG_W'(FMT_34));
      cards = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000,
                32'h0100_0000};
      foreach (cards[i]) begin
         queue_send(cards[i]);
         queue_ticks(frame_ticks(FMT_34, 1, 1) + 2);
      end
      // shorten a frame in flight
      queue_send(32'h1234_5678);
      queue_ticks(40);
      drain();
      write_reg(CSR_FRAME_FORMAT, TICK_REG_W'(FMT_26));
      queue_ticks(20);
      // lengthen a frame in flight
      queue_send(32'h0087_6543);
      queue_ticks(50);
      drain();
      write_reg(CSR_FRAME_FORMAT, TICK_REG_W'(FMT_34));
      queue_ticks(30);
      drain();

      // zero timing acts as one tick
      set_timing(FMT_26, 0, 0);
      queue_send(32'h00c3_3c3c);
      queue_ticks(frame_ticks(FMT_26, 0, 0) + 2);
      drain();
      write_reg(CSR_PULSE_GAP, 2);
      queue_send(32'h003c_c3c3);
      queue_ticks(frame_ticks(FMT_26, 0, 2) + 2);
      drain();

      // longest timing, restarted before it ends
      set_timing(FMT_34, {TICK_REG_W{1'b1}}, {TICK_REG_W{1'b1}});
      queue_send(32'hdead_beef);
      queue_ticks(30);
      queue_send(32'h0bad_cafe);
      queue_ticks(10);
      drain();
      write_reg(CSR_PULSE_WIDTH, 2);
      queue_send(32'h1357_9bdf);
      queue_ticks(8);
      drain();

      random_items = 0;
      while (random_items < 200) begin
         fmt = 1'($urandom_range(1));
         width = pick_ticks();
         gap = pick_ticks();
         drain();
         set_timing(fmt, width, gap);
         repeat ($urandom_range(1, 3)) begin
            full = frame_ticks(fmt, width, gap);
            kind = $urandom_range(9);
            if (kind <= 6) begin
               count = full + $urandom_range(3);
               queue_send($urandom);
               queue_ticks(count);
               random_items += count + 1;
            end else if (kind <= 8) begin
               count = $urandom_range(1, full - 1);
               queue_send($urandom);
               queue_ticks(count);
               random_items += count + 1;
            end else begin
               queue_ticks($urandom_range(5));
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
